>>> rtl/core/dma_pkg.sv
// ----------------------------------------------------------------------------
// Drive mode arbiter package
// Shared types, codes and helper functions of the drive mode arbiter.
// ----------------------------------------------------------------------------
package dma_pkg;

  // Widths of the item fields and configuration registers
  localparam int unsigned SelW     = 3;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned SpeedW   = 10;
  localparam int unsigned InclineW = 8;
  localparam int unsigned RawW     = 14;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  // Reset values of the clamp registers
  localparam logic [SpeedW-1:0]   MaxSpeedReset   = 10'd120;
  localparam logic [InclineW-1:0] MaxInclineReset = 8'd15;

  // Drive modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PROXY = 2'd1,
    MODE_EMU   = 2'd2
  } mode_e;

  // Event selector codes
  typedef enum logic [SelW-1:0] {
    EV_PROXY    = 3'd0,
    EV_EMULATE  = 3'd1,
    EV_SPEED    = 3'd2,
    EV_INCLINE  = 3'd3,
    EV_CONSOLE  = 3'd4,
    EV_SAFETY   = 3'd5,
    EV_WATCHDOG = 3'd6
  } event_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_SPEED   = 1'd0,
    CFG_MAX_INCLINE = 1'd1
  } cfg_idx_e;

  // One input event
  typedef struct packed {
    logic [SelW-1:0]          sel;
    logic                     enable;
    logic signed [ValueW-1:0] value;
    logic                     console_differs;
    logic                     key_is_motion;
  } item_t;

  // Architectural state
  typedef struct packed {
    mode_e               mode;
    logic [SpeedW-1:0]   speed;
    logic [InclineW-1:0] incline;
  } state_t;

  // One result
  typedef struct packed {
    logic                changed;
    logic                emu_entered;
    logic                emu_left;
    mode_e               mode;
    logic [SpeedW-1:0]   speed;
    logic [RawW-1:0]     motor_speed;
    logic [InclineW-1:0] incline;
  } result_t;

  // Clamp a signed request into 0..hi
  function automatic logic [SpeedW-1:0] clamp_value(logic signed [ValueW-1:0] v,
                                                    logic [SpeedW-1:0] hi);
    logic [ValueW-2:0] mag;
    mag = v[ValueW-2:0];
    if (v[ValueW-1]) begin
      return '0;
    end else if (mag > {{(ValueW-1-SpeedW){1'b0}}, hi}) begin
      return hi;
    end else begin
      return mag[SpeedW-1:0];
    end
  endfunction

  // Speed in raw motor units: tenths times ten, as two shifts and an add
  function automatic logic [RawW-1:0] speed_to_raw(logic [SpeedW-1:0] s);
    return {1'b0, s, 3'b000} + {3'b000, s, 1'b0};
  endfunction

endpackage

>>> rtl/core/dma_event_logic.sv
// ----------------------------------------------------------------------------
// Drive mode arbiter event logic
// Applies one event to the current mode and setpoints and forms the result.
// ----------------------------------------------------------------------------
module dma_event_logic (
  input  dma_pkg::item_t                     item_i,
  input  dma_pkg::state_t                    state_i,
  input  logic [dma_pkg::SpeedW-1:0]         max_speed_i,
  input  logic [dma_pkg::InclineW-1:0]       max_incline_i,
  output dma_pkg::state_t                    state_o,
  output dma_pkg::result_t                   result_o
);

  logic                      emu;
  logic                      chg;
  logic                      started;
  logic                      stopped;
  logic [dma_pkg::SpeedW-1:0] clamp_hi;
  logic [dma_pkg::SpeedW-1:0] clamped;
  dma_pkg::state_t           nxt;

  assign emu = (state_i.mode == dma_pkg::MODE_EMU);

  // Clamp limit follows the kind of setpoint
  assign clamp_hi = (item_i.sel == dma_pkg::EV_SPEED) ? max_speed_i
                  : {{(dma_pkg::SpeedW-dma_pkg::InclineW){1'b0}}, max_incline_i};
  assign clamped  = dma_pkg::clamp_value(item_i.value, clamp_hi);

  // Event rules
  always_comb begin
    nxt     = state_i;
    chg     = 1'b0;
    started = 1'b0;
    stopped = 1'b0;
    unique case (item_i.sel) inside
      dma_pkg::EV_PROXY: begin
        if (item_i.enable) begin
          stopped  = emu;
          nxt.mode = dma_pkg::MODE_PROXY;
          chg      = 1'b1;
        end else if (state_i.mode == dma_pkg::MODE_PROXY) begin
          nxt.mode = dma_pkg::MODE_IDLE;
          chg      = 1'b1;
        end
      end
      dma_pkg::EV_EMULATE: begin
        if (item_i.enable) begin
          if (!emu) begin
            nxt.mode    = dma_pkg::MODE_EMU;
            nxt.speed   = '0;
            nxt.incline = '0;
            started     = 1'b1;
            chg         = 1'b1;
          end
        end else if (emu) begin
          nxt.mode = dma_pkg::MODE_IDLE;
          stopped  = 1'b1;
          chg      = 1'b1;
        end
      end
      dma_pkg::EV_SPEED, dma_pkg::EV_INCLINE: begin
        // A setpoint outside emulation enters it with both setpoints zeroed
        if (!emu) begin
          nxt.mode    = dma_pkg::MODE_EMU;
          nxt.speed   = '0;
          nxt.incline = '0;
          started     = 1'b1;
          chg         = 1'b1;
        end
        if (item_i.sel == dma_pkg::EV_SPEED) begin
          nxt.speed = clamped;
        end else begin
          nxt.incline = clamped[dma_pkg::InclineW-1:0];
        end
      end
      dma_pkg::EV_CONSOLE: begin
        // A motion key touched on the console hands control back
        if (item_i.console_differs && item_i.key_is_motion && emu) begin
          nxt.mode = dma_pkg::MODE_PROXY;
          stopped  = 1'b1;
          chg      = 1'b1;
        end
      end
      dma_pkg::EV_SAFETY: begin
        nxt.speed   = '0;
        nxt.incline = '0;
      end
      dma_pkg::EV_WATCHDOG: begin
        nxt.speed   = '0;
        nxt.incline = '0;
        nxt.mode    = dma_pkg::MODE_PROXY;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

  // Result fields
  always_comb begin
    result_o.changed     = chg;
    result_o.emu_entered = started;
    result_o.emu_left    = stopped;
    result_o.mode        = nxt.mode;
    result_o.speed       = nxt.speed;
    result_o.motor_speed = dma_pkg::speed_to_raw(nxt.speed);
    result_o.incline     = nxt.incline;
  end

endmodule

>>> rtl/core/drive_mode_arbiter.sv
// ----------------------------------------------------------------------------
// Drive mode arbiter
// Holds the drive mode and setpoints and turns each event into one result.
// ----------------------------------------------------------------------------
// Each event transaction is taken into an input register, applied to the
// mode and setpoint registers by one stage of logic, and its result is held
// in an output register until the downstream side takes it. One event is
// accepted every cycle while results flow; the event passes from the input
// register through the event logic into the output register, which holds it
// while the downstream side stalls. The input stage refills in the same cycle
// that it hands its event on, so the rate is set only by the output register draining.
module drive_mode_arbiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [dma_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dma_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Event stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // enable[0], setpoint_value[16:1], console_differs[17], key_is_motion[18]
  input  logic [23:0]                   s_axis_tdata,
  // event selector[2:0]
  input  logic [2:0]                    s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // changed[0], emulation entered[1], emulation left[2], current_mode[4:3],
  // speed_tenths_out[14:5], motor speed[28:15], incline_out[36:29]
  output logic [39:0]                   m_axis_tdata
);

  logic                           in_valid_q;
  dma_pkg::item_t                 in_item_q;
  dma_pkg::state_t                state_q;
  dma_pkg::state_t                state_d;
  logic [dma_pkg::SpeedW-1:0]     max_speed_q;
  logic [dma_pkg::InclineW-1:0]   max_incline_q;
  logic                           out_valid_q;
  dma_pkg::result_t               out_res_q;
  dma_pkg::result_t               res_d;
  logic                           advance;
  dma_pkg::item_t                 item_in;

  // Pipeline control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Unpack the incoming transaction
  always_comb begin
    item_in.sel             = s_axis_tuser;
    item_in.enable          = s_axis_tdata[0];
    item_in.value           = s_axis_tdata[16:1];
    item_in.console_differs = s_axis_tdata[17];
    item_in.key_is_motion   = s_axis_tdata[18];
  end

  // Clamp registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= dma_pkg::MaxSpeedReset;
      max_incline_q <= dma_pkg::MaxInclineReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dma_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_wdata_i;
        dma_pkg::CFG_MAX_INCLINE: max_incline_q <= cfg_wdata_i[dma_pkg::InclineW-1:0];
        default:                  max_speed_q   <= max_speed_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= item_in;
    end
  end

  // Event rules
  dma_event_logic u_event_logic (
    .item_i        (in_item_q),
    .state_i       (state_q),
    .max_speed_i   (max_speed_q),
    .max_incline_i (max_incline_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // Mode and setpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= dma_pkg::MODE_IDLE;
      state_q.speed   <= '0;
      state_q.incline <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  // Pack the outgoing transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_res_q.incline,
                          out_res_q.motor_speed,
                          out_res_q.speed,
                          out_res_q.mode,
                          out_res_q.emu_left,
                          out_res_q.emu_entered,
                          out_res_q.changed};

  // Assertions
  a_started_in_emu : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.emu_entered |-> out_res_q.mode == dma_pkg::MODE_EMU)
    else $error("emulation start reported outside emulation");

  a_stopped_left_emu : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.emu_left |-> out_res_q.mode != dma_pkg::MODE_EMU)
    else $error("emulation stop reported while still emulating");

  a_start_stop_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.emu_entered && out_res_q.emu_left))
    else $error("emulation both started and stopped");

  a_raw_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_res_q.motor_speed == dma_pkg::speed_to_raw(out_res_q.speed))
    else $error("raw speed does not match setpoint");

  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an event");

endmodule
